@@ sv/ppe_pkg.sv @@
// ----------------------------------------------------------------------------
// ppe_pkg
// shared types and constants of the projectile pool engine
// ----------------------------------------------------------------------------
package ppe_pkg;

    localparam int SLOT_CAP = 32;   // slot_index is 5 bits wide
    localparam int SLOT_W   = 5;
    localparam int POS_W    = 20;   // signed q16.4
    localparam int SIZE_W   = 12;   // unsigned q8.4
    localparam int HIT_W    = 8;
    localparam int LIFE_W   = 16;   // unsigned q4.12
    localparam int TINT_W   = 32;
    localparam int DT_W     = 12;   // unsigned q0.12
    localparam int PROD_W   = POS_W + DT_W + 1;

    typedef enum logic [1:0] {
        CMD_SPAWN = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPAWN_OUT,
        ST_TICK,
        ST_TICK_DRAIN,
        ST_READ_ADDR,
        ST_READ_DATA,
        ST_READ_EMPTY
    } state_t;

    // per-slot values rewritten by every tick
    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [LIFE_W-1:0]       life;
    } slot_dyn_t;

    // per-slot values written only by a spawn
    typedef struct packed {
        logic signed [POS_W-1:0] vel_x;
        logic signed [POS_W-1:0] vel_y;
        logic [SIZE_W-1:0]       radius;
        logic [HIT_W-1:0]        damage;
        logic [TINT_W-1:0]       color;
    } slot_stat_t;

    // slot entering the motion stage
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] idx;
    } rd_ctl_t;

    // write back of one moved slot
    typedef struct packed {
        logic              valid;
        logic              expire;
        logic [SLOT_W-1:0] idx;
    } wb_ctl_t;

endpackage

@@ sv/projectile_pool_engine.sv @@
// ----------------------------------------------------------------------------
// projectile_pool_engine
// fixed pool of moving particles with spawn, tick and readout commands
// ----------------------------------------------------------------------------
//
//  channel   ports        role                       handshake
//  --------  -----------  -------------------------  ---------------
//  command   s_*          spawn, tick, readout       s_valid/s_ready
//  result    m_*          slot grant, slot readout   m_valid/m_ready
//
//  spawn: lowest free slot, if any, written at acceptance, result loaded
//  from the spawn-out state once the output register is free
//  tick: a sweep over every usable slot after acceptance, then a drain
//  while the last slots leave the two-stage motion path
//  readout: free slots are skipped, an active slot is read in the address state
//  and loaded in the data state once the output register is free, then the
//  sweep closes; with no active slot the empty item follows once the register is free
//  reset: synchronous, clears live flags, control and output valid only;
//  slot memory is not cleared, a slot is written before it goes live
//  stalls: m_ready low holds the output register; a spawn or readout waits for it,
//  s_ready is low until the current transaction's work is done
//
module projectile_pool_engine #(
    parameter int POOL_SIZE = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // command channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_cmd,
    input  logic signed [ppe_pkg::POS_W-1:0]       s_spawn_x,
    input  logic signed [ppe_pkg::POS_W-1:0]       s_spawn_y,
    input  logic signed [ppe_pkg::POS_W-1:0]       s_speed_x,
    input  logic signed [ppe_pkg::POS_W-1:0]       s_speed_y,
    input  logic [ppe_pkg::SIZE_W-1:0]             s_size_in,
    input  logic [ppe_pkg::HIT_W-1:0]              s_hit_value_in,
    input  logic [ppe_pkg::LIFE_W-1:0]             s_life_in,
    input  logic [ppe_pkg::TINT_W-1:0]             s_tint_in,
    input  logic [ppe_pkg::DT_W-1:0]               s_step_time,
    // result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [ppe_pkg::SLOT_W-1:0]             m_slot_index,
    output logic                                   m_ok,
    output logic signed [ppe_pkg::POS_W-1:0]       m_cur_x,
    output logic signed [ppe_pkg::POS_W-1:0]       m_cur_y,
    output logic [ppe_pkg::SIZE_W-1:0]             m_size_out,
    output logic [ppe_pkg::HIT_W-1:0]              m_hit_value_out,
    output logic [ppe_pkg::TINT_W-1:0]             m_tint_out,
    output logic                                   m_last
);

    // usable slots, capped by the slot_index width
    localparam int N  = (POOL_SIZE > ppe_pkg::SLOT_CAP) ? ppe_pkg::SLOT_CAP : POOL_SIZE;
    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int CW = $clog2(N + 1);

    // control state
    ppe_pkg::state_t                 state_reg, state_next;
    logic [N-1:0]                    live_reg;
    logic [CW-1:0]                   cnt_reg;
    logic [ppe_pkg::DT_W-1:0]        dt_reg;
    logic                            rd_valid_reg;
    logic [IW-1:0]                   rd_idx_reg;
    logic [IW-1:0]                   spawn_slot_reg;
    logic                            spawn_ok_reg;
    logic                            emitted_reg;

    // output register
    logic                            out_valid_reg;
    logic [ppe_pkg::SLOT_W-1:0]      out_slot_reg;
    logic                            out_ok_reg;
    logic signed [ppe_pkg::POS_W-1:0] out_x_reg, out_y_reg;
    logic [ppe_pkg::SIZE_W-1:0]      out_size_reg;
    logic [ppe_pkg::HIT_W-1:0]       out_hit_reg;
    logic [ppe_pkg::TINT_W-1:0]      out_tint_reg;
    logic                            out_last_reg;

    // combinational control
    logic                            accept;
    ppe_pkg::cmd_t                   cmd;
    logic                            free_found;
    logic [IW-1:0]                   free_idx;
    logic                            sweep_done;
    logic                            cur_live;
    logic                            more_live;
    logic                            spawn_wr;
    logic                            tick_issue;
    logic                            read_issue;
    logic                            read_skip;
    logic                            load_spawn, load_read, load_empty;

    // memory and motion path
    logic                            dyn_we;
    logic [IW-1:0]                   waddr;
    ppe_pkg::slot_dyn_t              dyn_wdata, dyn_rdata, wb_dyn;
    ppe_pkg::slot_stat_t             stat_wdata, stat_rdata;
    ppe_pkg::rd_ctl_t                mot_in;
    ppe_pkg::wb_ctl_t                wb;

    assign cmd        = ppe_pkg::cmd_t'(s_cmd);
    assign accept     = s_valid && s_ready;
    assign sweep_done = (cnt_reg == CW'(N));
    assign cur_live   = !sweep_done && live_reg[cnt_reg[IW-1:0]];

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!live_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    // any active slot above the one being read decides last
    always_comb begin
        more_live = 1'b0;
        for (int i = 0; i < N; i++) begin
            if (live_reg[i] && (i > int'(cnt_reg))) begin
                more_live = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ppe_pkg::ST_IDLE: begin
                if (accept) begin
                    case (cmd)
                        ppe_pkg::CMD_SPAWN: state_next = ppe_pkg::ST_SPAWN_OUT;
                        ppe_pkg::CMD_TICK:  state_next = ppe_pkg::ST_TICK;
                        ppe_pkg::CMD_READ:  state_next = ppe_pkg::ST_READ_ADDR;
                        default:            state_next = ppe_pkg::ST_IDLE;
                    endcase
                end
            end
            ppe_pkg::ST_SPAWN_OUT: begin
                if (!out_valid_reg) state_next = ppe_pkg::ST_IDLE;
            end
            ppe_pkg::ST_TICK: begin
                if (cnt_reg == CW'(N - 1)) state_next = ppe_pkg::ST_TICK_DRAIN;
            end
            ppe_pkg::ST_TICK_DRAIN: begin
                if (!rd_valid_reg && !wb.valid) state_next = ppe_pkg::ST_IDLE;
            end
            ppe_pkg::ST_READ_ADDR: begin
                if (sweep_done) begin
                    state_next = emitted_reg ? ppe_pkg::ST_IDLE : ppe_pkg::ST_READ_EMPTY;
                end else if (cur_live && !out_valid_reg) begin
                    state_next = ppe_pkg::ST_READ_DATA;
                end
            end
            ppe_pkg::ST_READ_DATA: begin
                state_next = ppe_pkg::ST_READ_ADDR;
            end
            ppe_pkg::ST_READ_EMPTY: begin
                if (!out_valid_reg) state_next = ppe_pkg::ST_IDLE;
            end
            default: state_next = ppe_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready    = (state_reg == ppe_pkg::ST_IDLE);
        spawn_wr   = 1'b0;
        tick_issue = 1'b0;
        read_issue = 1'b0;
        read_skip  = 1'b0;
        load_spawn = 1'b0;
        load_read  = 1'b0;
        load_empty = 1'b0;
        case (state_reg)
            ppe_pkg::ST_IDLE:       spawn_wr   = accept && (cmd == ppe_pkg::CMD_SPAWN)
                                                 && free_found;
            ppe_pkg::ST_SPAWN_OUT:  load_spawn = !out_valid_reg;
            ppe_pkg::ST_TICK:       tick_issue = 1'b1;
            ppe_pkg::ST_READ_ADDR: begin
                read_issue = cur_live && !out_valid_reg;
                read_skip  = !sweep_done && !cur_live;
            end
            ppe_pkg::ST_READ_DATA:  load_read  = 1'b1;
            ppe_pkg::ST_READ_EMPTY: load_empty = !out_valid_reg;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ppe_pkg::ST_IDLE;
            live_reg     <= '0;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            emitted_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= tick_issue && cur_live;
            if (accept) begin
                cnt_reg     <= '0;
                emitted_reg <= 1'b0;
            end else if (tick_issue || read_skip || load_read) begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (load_read) emitted_reg <= 1'b1;
            if (spawn_wr) live_reg[free_idx] <= 1'b1;
            // slot retires when its lifetime runs out
            if (wb.valid && wb.expire) live_reg[wb.idx[IW-1:0]] <= 1'b0;
        end
    end

    // command payload captured at acceptance
    always_ff @(posedge aclk) begin
        rd_idx_reg <= cnt_reg[IW-1:0];
        if (accept) begin
            dt_reg         <= s_step_time;
            spawn_slot_reg <= free_found ? free_idx : '0;
            spawn_ok_reg   <= free_found;
        end
    end

    // output register, loaded only while empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_spawn || load_read || load_empty) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_read) begin
            out_slot_reg <= ppe_pkg::SLOT_W'(cnt_reg[IW-1:0]);
            out_ok_reg   <= 1'b1;
            out_x_reg    <= dyn_rdata.pos_x;
            out_y_reg    <= dyn_rdata.pos_y;
            out_size_reg <= stat_rdata.radius;
            out_hit_reg  <= stat_rdata.damage;
            out_tint_reg <= stat_rdata.color;
            out_last_reg <= !more_live;
        end else if (load_spawn || load_empty) begin
            out_slot_reg <= load_spawn ? ppe_pkg::SLOT_W'(spawn_slot_reg) : '0;
            out_ok_reg   <= load_spawn && spawn_ok_reg;
            out_x_reg    <= '0;
            out_y_reg    <= '0;
            out_size_reg <= '0;
            out_hit_reg  <= '0;
            out_tint_reg <= '0;
            out_last_reg <= 1'b1;
        end
    end

    // memory write: spawn while idle, tick write back otherwise
    assign dyn_we           = spawn_wr || wb.valid;
    assign waddr            = spawn_wr ? free_idx : wb.idx[IW-1:0];
    assign dyn_wdata        = spawn_wr ? ppe_pkg::slot_dyn_t'{pos_x: s_spawn_x,
                                                               pos_y: s_spawn_y,
                                                               life:  s_life_in}
                                       : wb_dyn;
    assign stat_wdata.vel_x  = s_speed_x;
    assign stat_wdata.vel_y  = s_speed_y;
    assign stat_wdata.radius = s_size_in;
    assign stat_wdata.damage = s_hit_value_in;
    assign stat_wdata.color  = s_tint_in;

    ppe_slot_ram #(
        .DEPTH (N),
        .AW    (IW)
    ) u_slot_ram (
        .aclk       (aclk),
        .dyn_we     (dyn_we),
        .stat_we    (spawn_wr),
        .waddr      (waddr),
        .dyn_wdata  (dyn_wdata),
        .stat_wdata (stat_wdata),
        .rd_en      (tick_issue || read_issue),
        .raddr      (cnt_reg[IW-1:0]),
        .dyn_rdata  (dyn_rdata),
        .stat_rdata (stat_rdata)
    );

    assign mot_in.valid = rd_valid_reg;
    assign mot_in.idx   = ppe_pkg::SLOT_W'(rd_idx_reg);

    ppe_motion u_motion (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_ctl  (mot_in),
        .in_dyn  (dyn_rdata),
        .vel_x   (stat_rdata.vel_x),
        .vel_y   (stat_rdata.vel_y),
        .dt      (dt_reg),
        .wb      (wb),
        .wb_dyn  (wb_dyn)
    );

    assign m_valid         = out_valid_reg;
    assign m_slot_index    = out_slot_reg;
    assign m_ok            = out_ok_reg;
    assign m_cur_x         = out_x_reg;
    assign m_cur_y         = out_y_reg;
    assign m_size_out      = out_size_reg;
    assign m_hit_value_out = out_hit_reg;
    assign m_tint_out      = out_tint_reg;
    assign m_last          = out_last_reg;

    // output register is never overwritten while holding a transaction
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_spawn || load_read || load_empty) |-> !out_valid_reg)
        else $error("output register loaded while full");

    // motion write back only happens inside a tick
    a_wb_in_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        wb.valid |-> (state_reg == ppe_pkg::ST_TICK || state_reg == ppe_pkg::ST_TICK_DRAIN))
        else $error("slot write back outside a tick");

    // a spawn never lands on an active slot
    a_spawn_free: assert property (@(posedge aclk) disable iff (!aresetn)
        spawn_wr |-> !live_reg[free_idx])
        else $error("spawn into an active slot");

    // back in idle the motion pipeline is empty
    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ppe_pkg::ST_IDLE) |-> (!rd_valid_reg && !wb.valid))
        else $error("idle with slots still in flight");

    // a non-final readout item leaves the readout sweep running
    a_read_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |->
            (state_reg == ppe_pkg::ST_READ_ADDR || state_reg == ppe_pkg::ST_READ_DATA))
        else $error("readout ended before its last item");

endmodule

@@ sv/ppe_slot_ram.sv @@
// ----------------------------------------------------------------------------
// ppe_slot_ram
// slot storage: one write port, one registered read port, two arrays
// ----------------------------------------------------------------------------
module ppe_slot_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                  aclk,
    input  logic                  dyn_we,
    input  logic                  stat_we,
    input  logic [AW-1:0]         waddr,
    input  ppe_pkg::slot_dyn_t    dyn_wdata,
    input  ppe_pkg::slot_stat_t   stat_wdata,
    input  logic                  rd_en,
    input  logic [AW-1:0]         raddr,
    output ppe_pkg::slot_dyn_t    dyn_rdata,
    output ppe_pkg::slot_stat_t   stat_rdata
);

    ppe_pkg::slot_dyn_t  dyn_mem  [DEPTH];
    ppe_pkg::slot_stat_t stat_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (dyn_we) begin
            dyn_mem[waddr] <= dyn_wdata;
        end
        if (stat_we) begin
            stat_mem[waddr] <= stat_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            dyn_rdata  <= dyn_mem[raddr];
            stat_rdata <= stat_mem[raddr];
        end
    end

endmodule

@@ sv/ppe_motion.sv @@
// ----------------------------------------------------------------------------
// ppe_motion
// one slot per cycle: velocity times dt, rounding, saturation, lifetime
// ----------------------------------------------------------------------------
module ppe_motion (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ppe_pkg::rd_ctl_t                    in_ctl,
    input  ppe_pkg::slot_dyn_t                  in_dyn,
    input  logic signed [ppe_pkg::POS_W-1:0]    vel_x,
    input  logic signed [ppe_pkg::POS_W-1:0]    vel_y,
    input  logic [ppe_pkg::DT_W-1:0]            dt,
    output ppe_pkg::wb_ctl_t                    wb,
    output ppe_pkg::slot_dyn_t                  wb_dyn
);

    localparam int PW = ppe_pkg::PROD_W;

    logic                                valid_reg;
    logic [ppe_pkg::SLOT_W-1:0]          idx_reg;
    logic                                expire_reg;
    logic signed [PW-1:0]                prod_x_reg, prod_y_reg;
    logic signed [PW-1:0]                prod_x_next, prod_y_next;
    logic signed [ppe_pkg::POS_W-1:0]    pos_x_reg, pos_y_reg;
    logic [ppe_pkg::LIFE_W-1:0]          life_reg, life_next;
    logic                                expire_next;

    // round half up to q.4, then clamp to the position range
    function automatic logic signed [ppe_pkg::POS_W-1:0] step_pos(
        input logic signed [ppe_pkg::POS_W-1:0] pos,
        input logic signed [PW-1:0]             prod
    );
        logic signed [PW:0]   sum;
        logic signed [PW-12:0] delta;
        logic signed [PW-10:0] np;
        sum   = {prod[PW-1], prod} + (PW+1)'(2048);
        delta = sum[PW:12];
        np    = {{(PW-9-ppe_pkg::POS_W){pos[ppe_pkg::POS_W-1]}}, pos}
              + {{2{delta[PW-12]}}, delta};
        if (np > (PW-9)'(524287)) begin
            step_pos = 20'sd524287;
        end else if (np < -(PW-9)'(524288)) begin
            step_pos = -20'sd524288;
        end else begin
            step_pos = np[ppe_pkg::POS_W-1:0];
        end
    endfunction

    always_comb begin
        prod_x_next = vel_x * $signed({1'b0, dt});
        prod_y_next = vel_y * $signed({1'b0, dt});
        expire_next = (in_dyn.life <= ppe_pkg::LIFE_W'(dt));
        life_next   = expire_next ? '0 : in_dyn.life - ppe_pkg::LIFE_W'(dt);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= in_ctl.idx;
        expire_reg <= expire_next;
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        pos_x_reg  <= in_dyn.pos_x;
        pos_y_reg  <= in_dyn.pos_y;
        life_reg   <= life_next;
    end

    assign wb.valid     = valid_reg;
    assign wb.expire    = expire_reg;
    assign wb.idx       = idx_reg;
    assign wb_dyn.pos_x = step_pos(pos_x_reg, prod_x_reg);
    assign wb_dyn.pos_y = step_pos(pos_y_reg, prod_y_reg);
    assign wb_dyn.life  = life_reg;

endmodule
